[rtl/srs_pkg.sv]
// shared constants, types and bracket table for the script run segmenter
`default_nettype none
package srs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int POS_BITS    = 16;
  localparam int NPAIRS      = 34;
  localparam int PAIR_W      = 6;
  localparam int SCRIPT_W    = 8;
  localparam int CP_W        = 21;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMMON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INHERITED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN   = 2'd2;

  typedef logic signed [STK_AW:0] stk_ptr_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXAM, S_POP, S_DECIDE, S_FIX, S_EMIT_BRK, S_FINISH, S_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [PAIR_W-1:0] idx;
  } pair_hit_t;

  localparam logic [CP_W-1:0] PAIR_TABLE [NPAIRS] = '{
    21'h0028, 21'h0029, 21'h003c, 21'h003e, 21'h005b, 21'h005d, 21'h007b, 21'h007d,
    21'h00ab, 21'h00bb, 21'h2018, 21'h2019, 21'h201c, 21'h201d, 21'h2039, 21'h203a,
    21'h3008, 21'h3009, 21'h300a, 21'h300b, 21'h300c, 21'h300d, 21'h300e, 21'h300f,
    21'h3010, 21'h3011, 21'h3014, 21'h3015, 21'h3016, 21'h3017, 21'h3018, 21'h3019,
    21'h301a, 21'h301b
  };

  // first table entry matching the code point
  function automatic pair_hit_t find_pair(input logic [CP_W-1:0] cp);
    pair_hit_t r;
    r = '0;
    for (int i = NPAIRS - 1; i >= 0; i--) begin
      if (PAIR_TABLE[i] == cp) begin
        r.hit = 1'b1;
        r.idx = PAIR_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/srs_if.sv]
// valid/ready channel interfaces for characters and runs
`default_nettype none
interface srs_in_if;
  logic                           valid;
  logic                           ready;
  logic [srs_pkg::CP_W-1:0]       code_point;
  logic [srs_pkg::SCRIPT_W-1:0]   script_code;
  logic                           first_char;
  logic                           last_char;
  modport source (output valid, code_point, script_code, first_char, last_char, input ready);
  modport sink   (input valid, code_point, script_code, first_char, last_char, output ready);
endinterface

interface srs_out_if;
  logic                           valid;
  logic                           ready;
  logic [srs_pkg::POS_BITS-1:0]   run_start;
  logic [srs_pkg::POS_BITS-1:0]   run_length;
  logic [srs_pkg::SCRIPT_W-1:0]   run_script;
  logic                           final_run;
  modport source (output valid, run_start, run_length, run_script, final_run, input ready);
  modport sink   (input valid, run_start, run_length, run_script, final_run, output ready);
endinterface
`default_nettype wire

[rtl/srs_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/script_run_segmenter_top.sv]
// script run segmenter top level: run tracking, bracket stack sequencer
//
//  channel  | dir | handshake       | payload
//  in_ch    | in  | valid/ready     | code_point, script_code, first_char, last_char
//  out_ch   | out | valid/ready     | run_start, run_length, run_script, final_run
//  cfg_*    | in  | write enable    | cfg_index, cfg_data
//
// a character passes idle, examine, decide and finish, plus a pop per stack entry read
// by a closer, a fix per opener script fix-up, an emit per run (examine repeats on a break)
// the bracket stack lives in two rams with a registered read; pops read one entry a cycle
// rst_n is synchronous; stack contents are not cleared, only the pointers
// results wait in an output register; a stall there holds the sequencer only when
// a new run must be emitted
`default_nettype none
module script_run_segmenter_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  srs_in_if.sink                                 in_ch,
  srs_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [srs_pkg::SCRIPT_W-1:0]      cfg_data
);

  localparam int AW = srs_pkg::STK_AW;
  localparam int SW = srs_pkg::SCRIPT_W;
  localparam int PW = srs_pkg::POS_BITS;
  localparam srs_pkg::stk_ptr_t TOP_LAST = srs_pkg::stk_ptr_t'(srs_pkg::STACK_DEPTH - 1);

  srs_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] common_r, inherited_r, unknown_r;

  logic [srs_pkg::CP_W-1:0] cp_r;
  logic [SW-1:0]            sc_in_r;
  logic                     last_r, last_nxt;
  logic                     forced_r, forced_nxt;
  logic [SW-1:0]            sc_eff_r, sc_eff_nxt;
  logic                     closer_r, closer_nxt;
  logic [srs_pkg::PAIR_W-1:0] want_r, want_nxt;

  srs_pkg::stk_ptr_t top_r, top_nxt, fix_r, fix_nxt;
  logic [SW-1:0]     cur_r, cur_nxt;
  logic [PW-1:0]     begin_r, begin_nxt, pos_r, pos_nxt;
  logic              has_r, has_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_start_r, out_start_nxt, out_len_r, out_len_nxt;
  logic [SW-1:0] out_script_r, out_script_nxt;
  logic          out_final_r, out_final_nxt;

  // ram ports
  logic                        pair_we, scr_we;
  logic [AW-1:0]               pair_waddr, scr_waddr, rd_addr;
  logic [srs_pkg::PAIR_W-1:0]  pair_wdata, pair_rdata;
  logic [SW-1:0]               scr_wdata, scr_rdata;

  srs_ram #(.WIDTH(srs_pkg::PAIR_W), .DEPTH(srs_pkg::STACK_DEPTH)) u_pair_ram (
    .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
    .raddr(rd_addr), .rdata(pair_rdata)
  );

  srs_ram #(.WIDTH(SW), .DEPTH(srs_pkg::STACK_DEPTH)) u_scr_ram (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(rd_addr), .rdata(scr_rdata)
  );

  function automatic logic is_real(input logic [SW-1:0] s, input logic [SW-1:0] inh,
                                   input logic [SW-1:0] unk);
    return (s > inh) && (s != unk);
  endfunction

  srs_pkg::pair_hit_t ph;
  logic              slot_free, accept_ok, in_xfer;
  logic [PW-1:0]     run_len;
  srs_pkg::stk_ptr_t top_dec, fix_inc;

  assign ph        = srs_pkg::find_pair(cp_r);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == srs_pkg::S_IDLE);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign run_len   = (pos_r == begin_r) ? PW'(1) : PW'(pos_r - begin_r);
  assign top_dec   = top_r - srs_pkg::stk_ptr_t'(1);
  assign fix_inc   = fix_r + srs_pkg::stk_ptr_t'(1);
  assign accept_ok = forced_r || !is_real(cur_r, inherited_r, unknown_r) ||
                     !is_real(sc_eff_r, inherited_r, unknown_r) || (cur_r == sc_eff_r);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.run_start  = out_start_r;
  assign out_ch.run_length = out_len_r;
  assign out_ch.run_script = out_script_r;
  assign out_ch.final_run  = out_final_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_r    <= '0;
      inherited_r <= SW'(1);
      unknown_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        srs_pkg::CFG_COMMON:    common_r    <= cfg_data;
        srs_pkg::CFG_INHERITED: inherited_r <= cfg_data;
        srs_pkg::CFG_UNKNOWN:   unknown_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srs_pkg::S_IDLE;
      top_r       <= '1;
      fix_r       <= '1;
      cur_r       <= '0;
      begin_r     <= '0;
      pos_r       <= '0;
      has_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      fix_r       <= fix_nxt;
      cur_r       <= cur_nxt;
      begin_r     <= begin_nxt;
      pos_r       <= pos_nxt;
      has_r       <= has_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cp_r    <= in_ch.code_point;
      sc_in_r <= in_ch.script_code;
    end
    last_r       <= last_nxt;
    forced_r     <= forced_nxt;
    sc_eff_r     <= sc_eff_nxt;
    closer_r     <= closer_nxt;
    want_r       <= want_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_script_r <= out_script_nxt;
    out_final_r  <= out_final_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    fix_nxt        = fix_r;
    cur_nxt        = cur_r;
    begin_nxt      = begin_r;
    pos_nxt        = pos_r;
    has_nxt        = has_r;
    last_nxt       = last_r;
    forced_nxt     = forced_r;
    sc_eff_nxt     = sc_eff_r;
    closer_nxt     = closer_r;
    want_nxt       = want_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_script_nxt = out_script_r;
    out_final_nxt  = out_final_r;
    pair_we        = 1'b0;
    scr_we         = 1'b0;
    pair_waddr     = top_r[AW-1:0];
    scr_waddr      = top_r[AW-1:0];
    pair_wdata     = '0;
    scr_wdata      = cur_r;
    rd_addr        = top_r[AW-1:0];

    case (state_r)
      srs_pkg::S_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_ch.last_char;
          // new string clears the run and stack pointers
          if (in_ch.first_char) begin
            top_nxt   = '1;
            fix_nxt   = '1;
            cur_nxt   = common_r;
            begin_nxt = '0;
            pos_nxt   = '0;
            has_nxt   = 1'b0;
          end
          forced_nxt = !(in_ch.first_char ? 1'b0 : has_r);
          state_nxt  = srs_pkg::S_EXAM;
        end
      end

      srs_pkg::S_EXAM: begin
        sc_eff_nxt = sc_in_r;
        closer_nxt = 1'b0;
        want_nxt   = {ph.idx[srs_pkg::PAIR_W-1:1], 1'b0};
        state_nxt  = srs_pkg::S_DECIDE;
        if (sc_in_r == common_r && ph.hit) begin
          if (!ph.idx[0]) begin
            // opener: push with the run's script, wrap when full
            top_nxt    = (top_r == TOP_LAST) ? '0 : top_r + srs_pkg::stk_ptr_t'(1);
            pair_we    = 1'b1;
            scr_we     = 1'b1;
            pair_waddr = top_nxt[AW-1:0];
            scr_waddr  = top_nxt[AW-1:0];
            pair_wdata = ph.idx;
            scr_wdata  = cur_r;
          end else begin
            closer_nxt = 1'b1;
            if (top_r >= 0) begin
              rd_addr   = top_r[AW-1:0];
              state_nxt = srs_pkg::S_POP;
            end
          end
        end
      end

      srs_pkg::S_POP: begin
        // compare the entry read last cycle, else read the one below
        if (pair_rdata == want_r) begin
          sc_eff_nxt = scr_rdata;
          if (top_r < fix_r) fix_nxt = top_r;
          state_nxt = srs_pkg::S_DECIDE;
        end else begin
          top_nxt = top_dec;
          rd_addr = top_dec[AW-1:0];
          if (top_dec < 0) begin
            if (top_dec < fix_r) fix_nxt = top_dec;
            state_nxt = srs_pkg::S_DECIDE;
          end
        end
      end

      srs_pkg::S_DECIDE: begin
        if (!accept_ok) begin
          state_nxt = srs_pkg::S_EMIT_BRK;
        end else if (!is_real(cur_r, inherited_r, unknown_r) &&
                     is_real(sc_eff_r, inherited_r, unknown_r)) begin
          cur_nxt   = sc_eff_r;
          state_nxt = (fix_r < top_r) ? srs_pkg::S_FIX : srs_pkg::S_FINISH;
        end else begin
          state_nxt = srs_pkg::S_FINISH;
        end
      end

      srs_pkg::S_FIX: begin
        // rewrite the script of openers pushed before the run's script was known
        scr_we    = 1'b1;
        scr_waddr = fix_inc[AW-1:0];
        scr_wdata = cur_r;
        fix_nxt   = fix_inc;
        if (fix_inc >= top_r) state_nxt = srs_pkg::S_FINISH;
      end

      srs_pkg::S_EMIT_BRK: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_start_nxt  = begin_r;
          out_len_nxt    = run_len;
          out_script_nxt = cur_r;
          out_final_nxt  = !last_r;
          begin_nxt      = pos_r;
          cur_nxt        = common_r;
          fix_nxt        = top_r;
          has_nxt        = 1'b0;
          forced_nxt     = 1'b1;
          state_nxt      = srs_pkg::S_EXAM;
        end
      end

      srs_pkg::S_FINISH: begin
        if (closer_r && top_r >= 0) begin
          top_nxt = top_dec;
          if (top_dec < fix_r) fix_nxt = top_dec;
        end
        has_nxt = 1'b1;
        if (pos_r != '1) pos_nxt = pos_r + PW'(1);
        state_nxt = last_r ? srs_pkg::S_EMIT_LAST : srs_pkg::S_IDLE;
      end

      srs_pkg::S_EMIT_LAST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_start_nxt  = begin_r;
          out_len_nxt    = run_len;
          out_script_nxt = cur_r;
          out_final_nxt  = 1'b1;
          begin_nxt      = pos_r;
          cur_nxt        = common_r;
          fix_nxt        = top_r;
          has_nxt        = 1'b0;
          state_nxt      = srs_pkg::S_IDLE;
        end
      end

      default: state_nxt = srs_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/srs_checker.sv]
// port-level checker for the script run segmenter, bound to the top level
`default_nettype none
module srs_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [srs_pkg::POS_BITS-1:0] out_run_length,
  input wire logic [srs_pkg::SCRIPT_W-1:0] out_run_script
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one character at a time: busy after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // a run is never empty
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_length != '0))
    else $error("zero-length run");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_run_length) &&
                                   $stable(out_run_script)))
    else $error("stalled result changed");

endmodule

bind script_run_segmenter_top srs_checker u_srs_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_run_length(out_ch.run_length), .out_run_script(out_ch.run_script)
);
`default_nettype wire

[tb/sv/script_run_segmenter_top_tb.sv]
// testbench for the script run segmenter: directed table, random strings, run prediction
`default_nettype none
module script_run_segmenter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2_000_000;
  localparam int SETTLE = 80;
  localparam int POS_MAX = (1 << srs_pkg::POS_BITS) - 1;

  typedef struct {
    logic [srs_pkg::POS_BITS-1:0] start;
    logic [srs_pkg::POS_BITS-1:0] len;
    logic [srs_pkg::SCRIPT_W-1:0] scr;
    logic                         fin;
  } run_t;

  typedef struct {
    logic [srs_pkg::CP_W-1:0]     cp;
    logic [srs_pkg::SCRIPT_W-1:0] sc;
    logic                         first;
    logic                         last;
    logic                         typed;
    logic [srs_pkg::POS_BITS-1:0] start;
    logic [srs_pkg::POS_BITS-1:0] len;
    logic [srs_pkg::SCRIPT_W-1:0] scr;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index = srs_pkg::CFG_COMMON;
  logic [srs_pkg::SCRIPT_W-1:0] cfg_data = '0;

  srs_in_if  in_ch ();
  srs_out_if out_ch ();

  script_run_segmenter_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [srs_pkg::SCRIPT_W-1:0] common_sc = 8'd0, inherit_sc = 8'd1, unknown_sc = 8'd255;
  int stk_pair [srs_pkg::STACK_DEPTH];
  logic [srs_pkg::SCRIPT_W-1:0] stk_scr [srs_pkg::STACK_DEPTH];
  int top = -1, mark = -1;
  logic [srs_pkg::SCRIPT_W-1:0] run_scr = 8'd0;
  int run_beg = 0, pos = 0;
  bit run_has = 0;

  run_t runs_due [$];
  int errors = 0;
  int snd_pct = 0, rcv_pct = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int cyc = 0;

  function automatic bit is_script(logic [srs_pkg::SCRIPT_W-1:0] s);
    return s > inherit_sc && s != unknown_sc;
  endfunction

  function automatic int bracket_of(logic [srs_pkg::CP_W-1:0] cp);
    for (int i = 0; i < srs_pkg::NPAIRS; i++)
      if (srs_pkg::PAIR_TABLE[i] == cp) return i;
    return -1;
  endfunction

  function automatic void clear_string();
    top = -1; mark = -1; run_scr = common_sc; run_beg = 0; pos = 0; run_has = 0;
  endfunction

  function automatic void open_run();
    run_beg = pos; run_scr = common_sc; mark = top; run_has = 0;
  endfunction

  // bracket matching and script resolution; 1 when the character joins the run
  function automatic bit take_char(logic [srs_pkg::CP_W-1:0] cp,
                                   logic [srs_pkg::SCRIPT_W-1:0] sc, bit forced);
    int pi;
    bit closer;
    logic [srs_pkg::SCRIPT_W-1:0] s;
    pi = -1;
    s = sc;
    if (s == common_sc) pi = bracket_of(cp);
    closer = pi >= 0 && pi[0];
    if (pi >= 0 && !closer) begin
      top++;
      if (top >= srs_pkg::STACK_DEPTH) top = 0;
      stk_pair[top] = pi;
      stk_scr[top] = run_scr;
    end else if (closer && top >= 0) begin
      while (top >= 0 && stk_pair[top] != (pi & ~1)) top--;
      if (top < mark) mark = top;
      if (top >= 0) s = stk_scr[top];
    end
    if (!(forced || !is_script(run_scr) || !is_script(s) || run_scr == s)) return 0;
    if (!is_script(run_scr) && is_script(s)) begin
      run_scr = s;
      while (mark < top) begin
        mark++;
        stk_scr[mark] = run_scr;
      end
    end
    if (closer && top >= 0) begin
      top--;
      if (top < mark) mark = top;
    end
    return 1;
  endfunction

  function automatic run_t close_run();
    run_t r;
    int n;
    n = pos - run_beg;
    if (n == 0) n = 1;
    r.start = run_beg[srs_pkg::POS_BITS-1:0];
    r.len = n[srs_pkg::POS_BITS-1:0];
    r.scr = run_scr;
    r.fin = 1'b0;
    return r;
  endfunction

  // runs caused by one accepted character
  function automatic void predict_runs(logic [srs_pkg::CP_W-1:0] cp,
                                       logic [srs_pkg::SCRIPT_W-1:0] sc,
                                       bit first, bit last, ref run_t got [$]);
    got.delete();
    if (first) clear_string();
    if (!take_char(cp, sc, !run_has)) begin
      got.push_back(close_run());
      open_run();
      void'(take_char(cp, sc, 1'b1));
    end
    run_has = 1;
    if (pos < POS_MAX) pos++;
    if (last) begin
      got.push_back(close_run());
      open_run();
    end
    if (got.size() > 0) got[got.size()-1].fin = 1'b1;
  endfunction

  // one character transfer; the predictor sees it at acceptance
  task automatic send_char(logic [srs_pkg::CP_W-1:0] cp, logic [srs_pkg::SCRIPT_W-1:0] sc,
                           bit first, bit last,
                           bit typed = 0, run_t typed_run = '{default: '0});
    run_t got [$];
    if (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.code_point <= cp;
    in_ch.script_code <= sc;
    in_ch.first_char <= first;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_runs(cp, sc, first, last, got);
    if (typed) runs_due.push_back(typed_run);
    else foreach (got[i]) runs_due.push_back(got[i]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [srs_pkg::SCRIPT_W-1:0] c, logic [srs_pkg::SCRIPT_W-1:0] i,
                           logic [srs_pkg::SCRIPT_W-1:0] u);
    cfg_we <= 1'b1; cfg_index <= srs_pkg::CFG_COMMON; cfg_data <= c;
    @(posedge clk);
    cfg_index <= srs_pkg::CFG_INHERITED; cfg_data <= i;
    @(posedge clk);
    cfg_index <= srs_pkg::CFG_UNKNOWN; cfg_data <= u;
    @(posedge clk);
    cfg_we <= 1'b0;
    common_sc = c; inherit_sc = i; unknown_sc = u;
  endtask

  // one random character of a string with home scripts s1/s2
  task automatic rand_char(logic [srs_pkg::SCRIPT_W-1:0] s1, logic [srs_pkg::SCRIPT_W-1:0] s2,
                           bit first, bit last);
    int k;
    logic [srs_pkg::CP_W-1:0] cp;
    logic [srs_pkg::SCRIPT_W-1:0] sc;
    k = $urandom_range(99);
    cp = srs_pkg::CP_W'($urandom_range(32'h10FFFF));
    if (k < 35) begin
      cp = srs_pkg::PAIR_TABLE[$urandom_range(srs_pkg::NPAIRS - 1)];
      sc = common_sc;
    end else if (k < 45) begin
      sc = common_sc;
    end else if (k < 52) begin
      sc = ($urandom_range(1)) ? inherit_sc : unknown_sc;
    end else if (k < 60) begin
      sc = srs_pkg::SCRIPT_W'($urandom_range(255));
    end else if (k < 63) begin
      cp = srs_pkg::PAIR_TABLE[$urandom_range(srs_pkg::NPAIRS - 1)];
      sc = srs_pkg::SCRIPT_W'($urandom_range(255));
    end else begin
      sc = ($urandom_range(3) == 0) ? s2 : s1;
    end
    if ($urandom_range(19) == 0) first = 1'($urandom_range(1));
    if ($urandom_range(19) == 0) last = 1'($urandom_range(1));
    send_char(cp, sc, first, last);
  endtask

  task automatic rand_strings(int count);
    int n;
    logic [srs_pkg::SCRIPT_W-1:0] s1, s2;
    while (count > 0) begin
      n = $urandom_range(1, 20);
      s1 = srs_pkg::SCRIPT_W'($urandom_range(255));
      s2 = srs_pkg::SCRIPT_W'($urandom_range(255));
      for (int i = 0; i < n; i++) rand_char(s1, s2, i == 0, i == n - 1);
      count -= n;
    end
  endtask

  // result channel back-pressure
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(rcv_pct > 0 && $urandom_range(99) < rcv_pct);
    end
  end

  // run check against the oldest expectation
  always @(posedge clk) begin
    run_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (runs_due.size() == 0) begin
        $display("%0t: run with none expected: start %0d len %0d script %0d final %0b",
                 $time, out_ch.run_start, out_ch.run_length, out_ch.run_script,
                 out_ch.final_run);
        errors++;
      end else begin
        e = runs_due.pop_front();
        if (out_ch.run_start !== e.start) begin
          $display("%0t: run_start expected %0d actual %0d", $time, e.start, out_ch.run_start);
          errors++;
        end
        if (out_ch.run_length !== e.len) begin
          $display("%0t: run_length expected %0d actual %0d", $time, e.len, out_ch.run_length);
          errors++;
        end
        if (out_ch.run_script !== e.scr) begin
          $display("%0t: run_script expected %0d actual %0d", $time, e.scr, out_ch.run_script);
          errors++;
        end
        if (out_ch.final_run !== e.fin) begin
          $display("%0t: final_run expected %0b actual %0b", $time, e.fin, out_ch.final_run);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  dir_row_t dir_rows [22] = '{
    '{21'h000061, 8'd20,  1, 1, 1, 16'd0, 16'd1, 8'd20},
    '{21'h10FFFF, 8'd255, 1, 1, 1, 16'd0, 16'd1, 8'd0},
    '{21'h000000, 8'd0,   1, 1, 1, 16'd0, 16'd1, 8'd0},
    '{21'h000028, 8'd0,   1, 0, 0, 0, 0, 0},
    '{21'h000078, 8'd20,  0, 0, 0, 0, 0, 0},
    '{21'h00005b, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h000079, 8'd1,   0, 0, 0, 0, 0, 0},
    '{21'h00005d, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h000029, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h00007a, 8'd30,  0, 0, 0, 0, 0, 0},
    '{21'h00007b, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h0000ab, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h0000bb, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h00007d, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h00301b, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h000077, 8'd30,  0, 1, 0, 0, 0, 0},
    '{21'h000028, 8'd0,   1, 0, 0, 0, 0, 0},
    '{21'h000028, 8'd0,   0, 0, 0, 0, 0, 0},
    '{21'h000071, 8'd40,  0, 0, 0, 0, 0, 0},
    '{21'h00003e, 8'd0,   0, 1, 0, 0, 0, 0},
    '{21'h00006b, 8'd50,  0, 1, 0, 0, 0, 0},
    '{21'h002018, 8'd0,   1, 1, 0, 0, 0, 0}
  };

  initial begin
    run_t tr;
    logic [srs_pkg::SCRIPT_W-1:0] cfgs [5][3] = '{
      '{8'd0, 8'd1, 8'd255}, '{8'd5, 8'd1, 8'd255}, '{8'd0, 8'd0, 8'd0},
      '{8'd255, 8'd255, 8'd255}, '{8'd7, 8'd3, 8'd9}
    };
    in_ch.valid <= 1'b0;
    in_ch.code_point <= '0;
    in_ch.script_code <= '0;
    in_ch.first_char <= 1'b0;
    in_ch.last_char <= 1'b0;
    foreach (stk_pair[i]) begin
      stk_pair[i] = 0;
      stk_scr[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset settings
    foreach (dir_rows[i]) begin
      tr = '{dir_rows[i].start, dir_rows[i].len, dir_rows[i].scr, 1'b1};
      send_char(dir_rows[i].cp, dir_rows[i].sc, dir_rows[i].first, dir_rows[i].last,
                dir_rows[i].typed, tr);
    end

    // stack wrap: more openers than entries, then closers
    for (int i = 0; i < 40; i++)
      send_char(srs_pkg::PAIR_TABLE[2 * (i % 17)], common_sc, i == 0, 0);
    send_char(21'h000041, 8'd60, 0, 0);
    for (int i = 0; i < 10; i++)
      send_char(srs_pkg::PAIR_TABLE[2 * (i % 17) + 1], common_sc, 0, i == 9);
    drain();

    // receiver holds off while characters keep coming
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    rand_strings(80);
    drain();

    for (int c = 0; c < 5; c++) begin
      write_cfg(cfgs[c][0], cfgs[c][1], cfgs[c][2]);
      for (int m = 0; m < 4; m++) begin
        snd_pct = (m == 1) ? 62 : (m == 3) ? 32 : 0;
        rcv_pct = (m == 2) ? 62 : (m == 3) ? 32 : 0;
        rand_strings(70);
        drain();
      end
    end
    snd_pct = 0;
    rcv_pct = 0;
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
rtl/srs_pkg.sv
rtl/srs_if.sv
rtl/srs_ram.sv
rtl/script_run_segmenter_top.sv
rtl/srs_checker.sv
tb/sv/script_run_segmenter_top_tb.sv
